[design/dcl_pkg.sv]
package dcl_pkg;

    localparam int MAX_POINTS_DEF = 256;
    localparam int DIST_BITS_DEF  = 32;

    localparam int EPS_W   = 32;
    localparam int MINP_W  = 9;
    localparam int PCNT_W  = 9;
    localparam int CFG_W   = 32;
    localparam int CFGI_W  = 2;
    localparam int LABEL_W = 9;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_RUN   = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [CFGI_W-1:0] CFG_EPS        = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_MIN_POINTS = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_POINT_CNT  = 2'd2;

    typedef struct packed {
        logic [EPS_W-1:0]  eps;
        logic [MINP_W-1:0] min_points;
        logic [PCNT_W-1:0] point_count;
    } cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WR2,
        ST_RD_WAIT,
        ST_OUTER,
        ST_CNT_ISSUE,
        ST_CNT_WAIT,
        ST_SEED_ISSUE,
        ST_SEED_WAIT,
        ST_Q_POP,
        ST_Q_WAIT,
        ST_EXP_ISSUE,
        ST_EXP_WAIT,
        ST_SET_OUT,
        ST_SET_CHK,
        ST_SB_ISSUE,
        ST_SB_WAIT,
        ST_EMIT
    } state_t;

endpackage

[design/dcl_if.sv]
interface dcl_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  first_point;
    logic [7:0]  second_point;
    logic [31:0] distance;

    modport source (output valid, req_type, first_point, second_point, distance, input ready);
    modport sink (input valid, req_type, first_point, second_point, distance, output ready);
endinterface

interface dcl_rsp_if;
    logic       valid;
    logic       ready;
    logic [8:0] cluster_label;
    logic [8:0] next_cluster_id;

    modport source (output valid, cluster_label, next_cluster_id, input ready);
    modport sink (input valid, cluster_label, next_cluster_id, output ready);
endinterface

[design/dcl_ram.sv]
module dcl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/dcl_ctrl.sv]
module dcl_ctrl #(
    parameter int MAX_POINTS = dcl_pkg::MAX_POINTS_DEF,
    parameter int DIST_BITS  = dcl_pkg::DIST_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  dcl_pkg::cfg_t cfg,
    dcl_req_if.sink       req,
    dcl_rsp_if.source     rsp
);

    import dcl_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int NW    = IDX_W + 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 2);
    localparam int LW    = CNT_W + 1;
    localparam int CMP_W = (CNT_W > MINP_W) ? CNT_W : MINP_W;
    localparam int EW    = (DIST_BITS > EPS_W) ? DIST_BITS : EPS_W;

    state_t state_reg, state_next;
    logic [NW-1:0]        i_reg, i_next;
    logic [NW-1:0]        b_reg, b_next;
    logic [NW-1:0]        head_reg, head_next;
    logic [NW-1:0]        len_reg, len_next;
    logic [IDX_W-1:0]     s_reg, s_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     clu_reg, clu_next;
    logic                 mode_reg, mode_next;
    logic                 found_reg, found_next;
    logic [DIST_BITS-1:0] best_d_reg, best_d_next;
    logic [CNT_W-1:0]     best_lbl_reg, best_lbl_next;
    logic [7:0]           wa_reg, wa_next;
    logic [7:0]           wb_reg, wb_next;
    logic [DIST_BITS-1:0] wd_reg, wd_next;
    logic [LABEL_W-1:0]   res_reg, res_next;
    logic                 out_valid_reg, out_valid_next;
    logic [LABEL_W-1:0]   out_label_reg, out_label_next;
    logic [LABEL_W-1:0]   out_id_reg, out_id_next;
    logic [MAX_POINTS-1:0] lvalid_reg, lvalid_next;
    logic [MAX_POINTS-1:0] cons_reg, cons_next;

    logic                   dist_we;
    logic [2*IDX_W-1:0]     dist_waddr;
    logic [DIST_BITS-1:0]   dist_wdata;
    logic [DIST_BITS-1:0]   dist_rdata;
    logic                   lbl_we;
    logic [IDX_W-1:0]       lbl_waddr;
    logic [LW-1:0]          lbl_wdata;
    logic [IDX_W-1:0]       lbl_raddr;
    logic [LW-1:0]          lbl_rdata;
    logic                   q_we;
    logic [IDX_W-1:0]       q_raddr;
    logic [IDX_W-1:0]       q_rdata;

    logic [NW-1:0]          n_pts;
    logic [IDX_W-1:0]       bi;
    logic                   self_pair;
    logic                   near;
    logic [DIST_BITS-1:0]   dist_val;
    logic                   core;
    logic                   lb_valid;
    logic                   lb_border;
    logic [CNT_W-1:0]       lb_id;
    logic                   accept;
    logic                   load_out;

    dcl_ram #(.WIDTH(DIST_BITS), .DEPTH(2 ** (2 * IDX_W))) u_dist_ram (
        .clk   (clk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (dist_wdata),
        .raddr ({s_reg, bi}),
        .rdata (dist_rdata)
    );

    dcl_ram #(.WIDTH(LW), .DEPTH(MAX_POINTS)) u_label_ram (
        .clk   (clk),
        .we    (lbl_we),
        .waddr (lbl_waddr),
        .wdata (lbl_wdata),
        .raddr (lbl_raddr),
        .rdata (lbl_rdata)
    );

    dcl_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS)) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (len_reg[IDX_W-1:0]),
        .wdata (bi),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    assign n_pts     = (32'(cfg.point_count) > MAX_POINTS) ? NW'(MAX_POINTS)
                                                           : NW'(cfg.point_count);
    assign bi        = b_reg[IDX_W-1:0];
    assign self_pair = (s_reg == bi);
    assign near      = self_pair ? (cfg.eps != '0) : (EW'(dist_rdata) < EW'(cfg.eps));
    assign dist_val  = self_pair ? '0 : dist_rdata;
    assign core      = CMP_W'(cnt_reg) >= CMP_W'(cfg.min_points);
    assign lb_valid  = lvalid_reg[bi];
    assign lb_border = lbl_rdata[LW-1];
    assign lb_id     = lbl_rdata[CNT_W-1:0];
    assign accept    = req.valid && req.ready;
    assign load_out  = (state_reg == ST_EMIT) && (!out_valid_reg || rsp.ready);

    assign req.ready           = (state_reg == ST_IDLE);
    assign rsp.valid           = out_valid_reg;
    assign rsp.cluster_label   = out_label_reg;
    assign rsp.next_cluster_id = out_id_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            b_reg         <= '0;
            head_reg      <= '0;
            len_reg       <= '0;
            s_reg         <= '0;
            cnt_reg       <= '0;
            clu_reg       <= CNT_W'(1);
            mode_reg      <= 1'b0;
            found_reg     <= 1'b0;
            best_d_reg    <= '0;
            best_lbl_reg  <= '0;
            wa_reg        <= '0;
            wb_reg        <= '0;
            wd_reg        <= '0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_label_reg <= '0;
            out_id_reg    <= '0;
            lvalid_reg    <= '0;
            cons_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            b_reg         <= b_next;
            head_reg      <= head_next;
            len_reg       <= len_next;
            s_reg         <= s_next;
            cnt_reg       <= cnt_next;
            clu_reg       <= clu_next;
            mode_reg      <= mode_next;
            found_reg     <= found_next;
            best_d_reg    <= best_d_next;
            best_lbl_reg  <= best_lbl_next;
            wa_reg        <= wa_next;
            wb_reg        <= wb_next;
            wd_reg        <= wd_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
            out_label_reg <= out_label_next;
            out_id_reg    <= out_id_next;
            lvalid_reg    <= lvalid_next;
            cons_reg      <= cons_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        b_next         = b_reg;
        head_next      = head_reg;
        len_next       = len_reg;
        s_next         = s_reg;
        cnt_next       = cnt_reg;
        clu_next       = clu_reg;
        mode_next      = mode_reg;
        found_next     = found_reg;
        best_d_next    = best_d_reg;
        best_lbl_next  = best_lbl_reg;
        wa_next        = wa_reg;
        wb_next        = wb_reg;
        wd_next        = wd_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_label_next = out_label_reg;
        out_id_next    = out_id_reg;
        lvalid_next    = lvalid_reg;
        cons_next      = cons_reg;

        dist_we    = 1'b0;
        dist_waddr = {IDX_W'(req.first_point), IDX_W'(req.second_point)};
        dist_wdata = DIST_BITS'(req.distance);
        lbl_we     = 1'b0;
        lbl_waddr  = s_reg;
        lbl_wdata  = '0;
        lbl_raddr  = bi;
        q_we       = 1'b0;
        q_raddr    = head_reg[IDX_W-1:0];

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                lbl_raddr = IDX_W'(req.first_point);
                if (accept)
                begin
                    wa_next = req.first_point;
                    wb_next = req.second_point;
                    wd_next = DIST_BITS'(req.distance);
                    priority case (req.req_type)
                        REQ_WRITE:
                        begin
                            if (32'(req.first_point) < MAX_POINTS
                                && 32'(req.second_point) < MAX_POINTS)
                            begin
                                dist_we    = 1'b1;
                                state_next = ST_WR2;
                            end
                        end
                        REQ_RUN:
                        begin
                            clu_next    = CNT_W'(1);
                            lvalid_next = '0;
                            i_next      = '0;
                            state_next  = ST_OUTER;
                        end
                        REQ_READ:
                        begin
                            state_next = ST_RD_WAIT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_WR2:
            begin
                dist_we    = 1'b1;
                dist_waddr = {IDX_W'(wb_reg), IDX_W'(wa_reg)};
                dist_wdata = wd_reg;
                state_next = ST_IDLE;
            end

            ST_RD_WAIT:
            begin
                res_next = '0;
                if (32'(wa_reg) < 32'(n_pts) && lvalid_reg[IDX_W'(wa_reg)]
                    && !lbl_rdata[LW-1] && lbl_rdata[CNT_W-1:0] != '0)
                begin
                    res_next = LABEL_W'(lbl_rdata[CNT_W-1:0]);
                end
                state_next = ST_EMIT;
            end

            ST_OUTER:
            begin
                if (i_reg >= n_pts)
                begin
                    i_next     = '0;
                    state_next = ST_SET_OUT;
                end
                else if (lvalid_reg[i_reg[IDX_W-1:0]])
                begin
                    i_next = i_reg + NW'(1);
                end
                else
                begin
                    s_next     = i_reg[IDX_W-1:0];
                    b_next     = '0;
                    cnt_next   = '0;
                    mode_next  = 1'b0;
                    state_next = ST_CNT_ISSUE;
                end
            end

            ST_CNT_ISSUE:
            begin
                if (b_reg >= n_pts)
                begin
                    b_next = '0;
                    if (!mode_reg)
                    begin
                        if (!core)
                        begin
                            lbl_we             = 1'b1;
                            lbl_wdata          = '0;
                            lvalid_next[s_reg] = 1'b1;
                            i_next             = i_reg + NW'(1);
                            state_next         = ST_OUTER;
                        end
                        else
                        begin
                            cons_next  = '0;
                            head_next  = '0;
                            len_next   = '0;
                            state_next = ST_SEED_ISSUE;
                        end
                    end
                    else if (core)
                    begin
                        lbl_we             = 1'b1;
                        lbl_wdata          = {1'b0, clu_reg};
                        lvalid_next[s_reg] = 1'b1;
                        state_next         = ST_EXP_ISSUE;
                    end
                    else
                    begin
                        state_next = ST_Q_POP;
                    end
                end
                else
                begin
                    state_next = ST_CNT_WAIT;
                end
            end

            ST_CNT_WAIT:
            begin
                if (near)
                begin
                    cnt_next = cnt_reg + (self_pair ? CNT_W'(2) : CNT_W'(1));
                end
                b_next     = b_reg + NW'(1);
                state_next = ST_CNT_ISSUE;
            end

            ST_SEED_ISSUE:
            begin
                state_next = (b_reg >= n_pts) ? ST_Q_POP : ST_SEED_WAIT;
            end

            ST_SEED_WAIT:
            begin
                if (near && !cons_reg[bi])
                begin
                    cons_next[bi] = 1'b1;
                    q_we          = 1'b1;
                    len_next      = len_reg + NW'(1);
                end
                b_next     = b_reg + NW'(1);
                state_next = ST_SEED_ISSUE;
            end

            ST_Q_POP:
            begin
                if (head_reg >= len_reg)
                begin
                    clu_next   = clu_reg + CNT_W'(1);
                    i_next     = i_reg + NW'(1);
                    state_next = ST_OUTER;
                end
                else
                begin
                    head_next  = head_reg + NW'(1);
                    state_next = ST_Q_WAIT;
                end
            end

            ST_Q_WAIT:
            begin
                s_next     = q_rdata;
                b_next     = '0;
                cnt_next   = '0;
                mode_next  = 1'b1;
                state_next = ST_CNT_ISSUE;
            end

            ST_EXP_ISSUE:
            begin
                state_next = (b_reg >= n_pts) ? ST_Q_POP : ST_EXP_WAIT;
            end

            ST_EXP_WAIT:
            begin
                if (near)
                begin
                    if (!lb_valid && !cons_reg[bi] && 32'(len_reg) < MAX_POINTS)
                    begin
                        cons_next[bi] = 1'b1;
                        q_we          = 1'b1;
                        len_next      = len_reg + NW'(1);
                    end
                    if (!lb_valid || (!lb_border && lb_id == '0))
                    begin
                        lbl_we          = 1'b1;
                        lbl_waddr       = bi;
                        lbl_wdata       = {1'b1, CNT_W'(0)};
                        lvalid_next[bi] = 1'b1;
                    end
                end
                b_next     = b_reg + NW'(1);
                state_next = ST_EXP_ISSUE;
            end

            ST_SET_OUT:
            begin
                lbl_raddr = i_reg[IDX_W-1:0];
                if (i_reg >= n_pts)
                begin
                    res_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    s_next     = i_reg[IDX_W-1:0];
                    state_next = ST_SET_CHK;
                end
            end

            ST_SET_CHK:
            begin
                if (lvalid_reg[s_reg] && lbl_rdata[LW-1])
                begin
                    found_next = 1'b0;
                    b_next     = '0;
                    state_next = ST_SB_ISSUE;
                end
                else
                begin
                    i_next     = i_reg + NW'(1);
                    state_next = ST_SET_OUT;
                end
            end

            ST_SB_ISSUE:
            begin
                if (b_reg >= n_pts)
                begin
                    lbl_we     = 1'b1;
                    lbl_wdata  = found_reg ? {1'b0, best_lbl_reg} : '0;
                    i_next     = i_reg + NW'(1);
                    state_next = ST_SET_OUT;
                end
                else
                begin
                    state_next = ST_SB_WAIT;
                end
            end

            ST_SB_WAIT:
            begin
                if (near && lb_valid && !lb_border && lb_id != '0
                    && (!found_reg || dist_val < best_d_reg))
                begin
                    found_next    = 1'b1;
                    best_d_next   = dist_val;
                    best_lbl_next = lb_id;
                end
                b_next     = b_reg + NW'(1);
                state_next = ST_SB_ISSUE;
            end

            ST_EMIT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    out_label_next = res_reg;
                    out_id_next    = LABEL_W'(clu_reg);
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[design/density_cluster_labeler.sv]
// Density clustering over a loaded matrix of pair distances.
// Channels: req (sink) takes request words, rsp (source) returns result words;
// both move a word when valid and ready are high at a rising clk edge.
// A distance write stores both halves of the symmetric pair when both points are
// below MAX_POINTS, and answers nothing. A label read answers the point's label
// and the next cluster id via ST_RD_WAIT and ST_EMIT into the result register.
// A run labels all n points (n = point_count, capped at MAX_POINTS) and answers
// label 0 with the new cluster id. Each matrix row scan goes through the single
// distance read port and the shared compare unit. A noise start costs one scan,
// a core start two, each point taken from a seed queue one more, or two when it
// is core, and each border point one more at the end.
// req is ready only while the sequencer is idle. One result register sits on rsp;
// a stalled receiver holds it, and the next request is still taken, but its
// result waits until the register is free.
// Config (cfg_we, cfg_index, cfg_data) writes eps, min_points, point_count.
// Reset clears all labels to unclassified, sets the cluster id to 1, eps and
// min_points to 0 and point_count to 1. The distance matrix is not cleared.
module density_cluster_labeler #(
    parameter int MAX_POINTS = dcl_pkg::MAX_POINTS_DEF,
    parameter int DIST_BITS  = dcl_pkg::DIST_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [dcl_pkg::CFGI_W-1:0] cfg_index,
    input  logic [dcl_pkg::CFG_W-1:0]  cfg_data,
    dcl_req_if.sink                    req,
    dcl_rsp_if.source                  rsp
);

    import dcl_pkg::*;

    cfg_t cfg_reg, cfg_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.eps         <= '0;
            cfg_reg.min_points  <= '0;
            cfg_reg.point_count <= PCNT_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            priority case (cfg_index)
                CFG_EPS:        cfg_next.eps         = EPS_W'(cfg_data);
                CFG_MIN_POINTS: cfg_next.min_points  = MINP_W'(cfg_data);
                CFG_POINT_CNT:  cfg_next.point_count = PCNT_W'(cfg_data);
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    dcl_ctrl #(
        .MAX_POINTS (MAX_POINTS),
        .DIST_BITS  (DIST_BITS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

[sim/dcl_label_checker.sv]
module dcl_label_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [dcl_pkg::CFGI_W-1:0] cfg_index,
    input  logic [dcl_pkg::CFG_W-1:0]  cfg_data,
    dcl_req_if                         req,
    dcl_rsp_if                         rsp,
    output int                         fail_count,
    output int                         pending
);
    import dcl_pkg::*;

    localparam int NPTS           = MAX_POINTS_DEF;
    localparam int LBL_UNCLASSIFIED = -2;
    localparam int LBL_BORDER     = -1;
    localparam int LBL_NOISE      = 0;
    localparam int QDEPTH         = 16;

    typedef struct packed {
        logic [LABEL_W-1:0] cluster_label;
        logic [LABEL_W-1:0] next_cluster_id;
    } label_word_t;

    logic [31:0]       dist_mem [NPTS*NPTS];
    int                point_label [NPTS];
    bit                seen [NPTS];
    int                seeds [NPTS];
    int                cluster_id;
    logic [EPS_W-1:0]  eps_r;
    logic [MINP_W-1:0] minp_r;
    logic [PCNT_W-1:0] pcnt_r;
    label_word_t       label_words [QDEPTH];
    int                q_wr;
    int                q_rd;

    function automatic logic [31:0] pair_distance(int a, int b);
        return (a == b) ? 32'd0 : dist_mem[a*NPTS+b];
    endfunction

    function automatic bit is_close(int a, int b);
        return pair_distance(a, b) < eps_r;
    endfunction

    function automatic int close_count(int a, int n);
        int c;
        c = 0;
        for (int b = 0; b < n; b++)
            if (is_close(a, b))
                c += (a == b) ? 2 : 1;
        return c;
    endfunction

    function automatic int live_points();
        return (pcnt_r > NPTS) ? NPTS : int'(pcnt_r);
    endfunction

    function automatic bit grow_from(int start, int n);
        int head;
        int len;
        int s;
        head = 0;
        len = 0;
        if (close_count(start, n) < minp_r)
        begin
            point_label[start] = LBL_NOISE;
            return 0;
        end
        for (int b = 0; b < NPTS; b++)
            seen[b] = 0;
        for (int b = 0; b < n; b++)
        begin
            if (is_close(start, b) && !seen[b])
            begin
                seen[b] = 1;
                seeds[len] = b;
                len++;
            end
        end
        while (head < len)
        begin
            s = seeds[head];
            head++;
            if (close_count(s, n) >= minp_r)
            begin
                point_label[s] = cluster_id;
                for (int b = 0; b < n; b++)
                begin
                    if (!is_close(s, b))
                        continue;
                    if (point_label[b] == LBL_UNCLASSIFIED && !seen[b] && len < NPTS)
                    begin
                        seen[b] = 1;
                        seeds[len] = b;
                        len++;
                    end
                    if (point_label[b] == LBL_UNCLASSIFIED || point_label[b] == LBL_NOISE)
                        point_label[b] = LBL_BORDER;
                end
            end
            seen[s] = 1;
        end
        return 1;
    endfunction

    function automatic void label_all();
        int          n;
        bit          found;
        logic [31:0] best_d;
        int          best;
        n = live_points();
        cluster_id = 1;
        for (int i = 0; i < NPTS; i++)
            point_label[i] = LBL_UNCLASSIFIED;
        for (int i = 0; i < n; i++)
            if (point_label[i] == LBL_UNCLASSIFIED && grow_from(i, n))
                cluster_id++;
        for (int i = 0; i < n; i++)
        begin
            if (point_label[i] != LBL_BORDER)
                continue;
            found = 0;
            best_d = '0;
            best = 0;
            for (int b = 0; b < n; b++)
            begin
                if (is_close(i, b) && point_label[b] > 0)
                begin
                    if (!found || pair_distance(i, b) < best_d)
                    begin
                        found = 1;
                        best_d = pair_distance(i, b);
                        best = b;
                    end
                end
            end
            point_label[i] = found ? point_label[best] : LBL_NOISE;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        label_word_t exp_w;
        label_word_t got_w;
        if (!rst_n)
        begin
            for (int i = 0; i < NPTS; i++)
                point_label[i] = LBL_UNCLASSIFIED;
            cluster_id = 1;
            eps_r = '0;
            minp_r = '0;
            pcnt_r = 9'd1;
            q_wr = 0;
            q_rd = 0;
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_EPS:        eps_r = cfg_data[EPS_W-1:0];
                    CFG_MIN_POINTS: minp_r = cfg_data[MINP_W-1:0];
                    CFG_POINT_CNT:  pcnt_r = cfg_data[PCNT_W-1:0];
                    default: ;
                endcase
            end
            if (rsp.valid && rsp.ready)
            begin
                got_w.cluster_label = rsp.cluster_label;
                got_w.next_cluster_id = rsp.next_cluster_id;
                if (q_wr == q_rd)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected word: label %0d id %0d",
                                 got_w.cluster_label, got_w.next_cluster_id);
                end
                else
                begin
                    exp_w = label_words[q_rd % QDEPTH];
                    q_rd++;
                    if (got_w != exp_w)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected label %0d id %0d, got label %0d id %0d",
                                     exp_w.cluster_label, exp_w.next_cluster_id,
                                     got_w.cluster_label, got_w.next_cluster_id);
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                case (req.req_type)
                    REQ_WRITE:
                    begin
                        dist_mem[req.first_point*NPTS+req.second_point] = req.distance;
                        dist_mem[req.second_point*NPTS+req.first_point] = req.distance;
                    end
                    REQ_RUN:
                    begin
                        label_all();
                        exp_w.cluster_label = '0;
                        exp_w.next_cluster_id = cluster_id[LABEL_W-1:0];
                        label_words[q_wr % QDEPTH] = exp_w;
                        q_wr++;
                    end
                    REQ_READ:
                    begin
                        exp_w.cluster_label = '0;
                        if (req.first_point < live_points() && point_label[req.first_point] > 0)
                            exp_w.cluster_label = point_label[req.first_point][LABEL_W-1:0];
                        exp_w.next_cluster_id = cluster_id[LABEL_W-1:0];
                        label_words[q_wr % QDEPTH] = exp_w;
                        q_wr++;
                    end
                    default: ;
                endcase
            end
        end
        pending = q_wr - q_rd;
    end
endmodule

[sim/tb_density_cluster_labeler.sv]
module tb_density_cluster_labeler;
    import dcl_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CFGI_W-1:0]   cfg_index;
    logic [CFG_W-1:0]    cfg_data;
    int                  fail_count;
    int                  pending;
    int                  send_idle_pct;
    int                  recv_stall_pct;
    int                  hold_left;
    int                  hold_seen;
    int                  hold_asks;
    int                  word_count;

    dcl_req_if req_ch ();
    dcl_rsp_if rsp_ch ();

    density_cluster_labeler uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    dcl_label_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12 * 4000000);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        rsp_ch.ready = 0;
        hold_left = 0;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_asks)
            begin
                hold_seen = hold_asks;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 0;
            end
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic send_word(logic [1:0] t, logic [7:0] a, logic [7:0] b, logic [31:0] d);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 0;
            @(posedge clk);
        end
        req_ch.valid <= 1;
        req_ch.req_type <= t;
        req_ch.first_point <= a;
        req_ch.second_point <= b;
        req_ch.distance <= d;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (t != REQ_UNUSED)
            word_count++;
    endtask

    task automatic set_regs(logic [31:0] eps, logic [31:0] minp, logic [31:0] pcnt);
        req_ch.valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we <= 1;
        cfg_index <= CFG_EPS;
        cfg_data <= eps;
        @(posedge clk);
        cfg_index <= CFG_MIN_POINTS;
        cfg_data <= minp;
        @(posedge clk);
        cfg_index <= CFG_POINT_CNT;
        cfg_data <= pcnt;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    function automatic logic [31:0] pick_distance();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(0, 200);
        endcase
    endfunction

    task automatic noise_word(int n);
        int a;
        case ($urandom_range(0, 3))
            0: send_word(REQ_UNUSED, 8'($urandom), 8'($urandom), $urandom);
            1:
            begin
                a = $urandom_range(0, 255);
                send_word(REQ_WRITE, 8'(a), 8'(a), $urandom);
            end
            2: send_word(REQ_WRITE, 8'($urandom_range(n, 255)), 8'($urandom_range(n, 255)),
                         $urandom);
            default: send_word(REQ_READ, 8'($urandom), 8'($urandom), $urandom);
        endcase
    endtask

    task automatic load_pairs(int n);
        for (int a = 0; a < n; a++)
            for (int b = a + 1; b < n; b++)
            begin
                if ($urandom_range(0, 9) == 0)
                    noise_word(n);
                if ($urandom_range(0, 1))
                    send_word(REQ_WRITE, 8'(a), 8'(b), pick_distance());
                else
                    send_word(REQ_WRITE, 8'(b), 8'(a), pick_distance());
            end
    endtask

    task automatic read_labels(int n, int k);
        for (int i = 0; i < k; i++)
        begin
            if ($urandom_range(0, 4) == 0 || n == 0)
                send_word(REQ_READ, 8'($urandom_range(0, 255)), 8'($urandom), $urandom);
            else
                send_word(REQ_READ, 8'($urandom_range(0, n - 1)), 8'($urandom), $urandom);
        end
    endtask

    initial
    begin
        int          n;
        int          phase;
        logic [31:0] eps;
        logic [31:0] minp;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 0;
        req_ch.req_type = REQ_WRITE;
        req_ch.first_point = '0;
        req_ch.second_point = '0;
        req_ch.distance = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_asks = 0;
        word_count = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_word(REQ_READ, 8'd0, 8'd0, 32'd0);
        send_word(REQ_RUN, 8'd0, 8'd0, 32'd0);
        send_word(REQ_READ, 8'd0, 8'd0, 32'd0);
        send_word(REQ_UNUSED, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        set_regs(32'hFFFF_FFFF, 32'd511, 32'd4);
        send_word(REQ_WRITE, 8'd0, 8'd1, 32'd0);
        send_word(REQ_WRITE, 8'd2, 8'd0, 32'hFFFF_FFFF);
        send_word(REQ_WRITE, 8'd0, 8'd3, 32'd5);
        send_word(REQ_WRITE, 8'd1, 8'd2, 32'd5);
        send_word(REQ_WRITE, 8'd3, 8'd1, 32'd5);
        send_word(REQ_WRITE, 8'd2, 8'd3, 32'hFFFF_FFFE);
        send_word(REQ_WRITE, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        send_word(REQ_RUN, 8'd0, 8'd0, 32'd0);
        send_word(REQ_READ, 8'd0, 8'd0, 32'd0);
        set_regs(32'd6, 32'd3, 32'd4);
        send_word(REQ_RUN, 8'd0, 8'd0, 32'd0);
        for (int i = 0; i < 4; i++)
            send_word(REQ_READ, 8'(i), 8'd0, 32'd0);
        send_word(REQ_READ, 8'd255, 8'd255, 32'd0);
        set_regs(32'd0, 32'd0, 32'd0);
        send_word(REQ_RUN, 8'd0, 8'd0, 32'd0);
        send_word(REQ_READ, 8'd0, 8'd0, 32'd0);

        phase = 0;
        while (word_count < 1550)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            n = (phase == 3) ? 48 : ($urandom_range(0, 7) == 0 ? 1 : $urandom_range(2, 16));
            case ($urandom_range(0, 7))
                0: eps = 32'd0;
                1: eps = 32'hFFFF_FFFF;
                2: eps = $urandom;
                default: eps = $urandom_range(1, 200);
            endcase
            case ($urandom_range(0, 7))
                0: minp = 32'd0;
                1: minp = 32'd511;
                2: minp = 32'd257;
                default: minp = $urandom_range(0, 2 * n + 3);
            endcase
            set_regs(eps, minp, 32'(n));
            load_pairs(n);
            send_word(REQ_RUN, 8'($urandom), 8'($urandom), $urandom);
            if (phase % 5 == 2)
                hold_asks++;
            read_labels(n, $urandom_range(4, 12));
            if ($urandom_range(0, 1))
            begin
                for (int i = 0; i < 3 && n > 1; i++)
                    send_word(REQ_WRITE, 8'($urandom_range(0, n - 1)),
                              8'($urandom_range(0, n - 1)), pick_distance());
                send_word(REQ_RUN, 8'($urandom), 8'($urandom), $urandom);
                read_labels(n, $urandom_range(2, 8));
            end
            phase++;
        end
        req_ch.valid <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
